// ===== hdl/dbba_pkg.sv =====
`default_nettype none
package dbba_pkg;

  localparam int unsigned SectorsPerTrackDefault = 21;
  localparam int unsigned TrackCountDefault      = 35;

  localparam logic [1:0] REQ_ALLOC     = 2'd0;
  localparam logic [1:0] REQ_FREE      = 2'd1;
  localparam logic [1:0] REQ_SET_POS   = 2'd2;
  localparam logic [1:0] REQ_RESET_POS = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [1:0] ST_ILLEGAL  = 2'd2;

  typedef enum logic [2:0] {
    CtlClear,
    CtlIdle,
    CtlExec,
    CtlRmw,
    CtlSearch,
    CtlFinish
  } ctl_state_e;

  typedef enum logic [2:0] {
    CurKeep,
    CurReq,
    CurHome,
    CurZero,
    CurFound
  } cur_sel_e;

  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       rd_req;
    logic       wr_alloc;
    logic       wr_free;
    logic       search_start;
    logic       search_step;
    cur_sel_e   cur_sel;
    logic       st_set;
    logic [1:0] st_val;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] req;
    logic       legal;
    logic       req_used;
    logic       start_wrap;
    logic       found;
    logic       none;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/disk_block_bitmap_allocator.sv =====
`default_nettype none
// Block usage map allocator over TRACK_COUNT tracks of SECTORS_PER_TRACK sectors,
// one bit per block in a byte-wide single-port-read memory, set meaning used.
// After reset a clearing pass writes the map to all free, one byte per cycle,
// over all ceil(TRACK_COUNT*SECTORS_PER_TRACK/8) map bytes, before the first
// request is taken. Reset position, set position and illegal requests are
// settled in the execute state; free and allocate of a free block go on to a
// read-modify-write of one map byte. Allocate of a used block scans forward
// one block per cycle through the map read port, probing at most the blocks
// after the request; a used last block leaves nothing to probe.
// A one-entry output register lets a result wait while the next request is taken.
module disk_block_bitmap_allocator #(
  parameter int unsigned SECTORS_PER_TRACK = dbba_pkg::SectorsPerTrackDefault,
  parameter int unsigned TRACK_COUNT       = dbba_pkg::TrackCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // track[5:0], sector[11:6], zero[15:12]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // track_out[5:0], sector_out[11:6], zero[15:12]
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  dbba_pkg::dp_cmd_t  cmd;
  dbba_pkg::dp_stat_t stat;
  logic [5:0]         trk_out, sec_out;

  dbba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dbba_datapath #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .TRACK_COUNT       (TRACK_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (s_axis_tuser),
    .trk_i       (s_axis_tdata[5:0]),
    .sec_i       (s_axis_tdata[11:6]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_o    (m_axis_tuser),
    .trk_o       (trk_out),
    .sec_o       (sec_out)
  );

  assign m_axis_tdata = {4'd0, sec_out, trk_out};

endmodule
`default_nettype wire

// ===== hdl/dbba_ctrl.sv =====
`default_nettype none
module dbba_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dbba_pkg::dp_stat_t stat_i,
  output dbba_pkg::dp_cmd_t      cmd_o
);

  dbba_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbba_pkg::CtlClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.cur_sel      = dbba_pkg::CurKeep;
    cmd_o.st_val       = dbba_pkg::ST_OK;
    case (state_q)
      dbba_pkg::CtlClear: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clr_done) state_d = dbba_pkg::CtlIdle;
      end
      dbba_pkg::CtlIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dbba_pkg::CtlExec;
        end
      end
      dbba_pkg::CtlExec: begin
        cmd_o.st_set = 1'b1;
        state_d      = dbba_pkg::CtlFinish;
        if (stat_i.req == dbba_pkg::REQ_RESET_POS) begin
          cmd_o.cur_sel = dbba_pkg::CurHome;
        end else if (!stat_i.legal) begin
          cmd_o.st_val = dbba_pkg::ST_ILLEGAL;
        end else if (stat_i.req == dbba_pkg::REQ_SET_POS) begin
          cmd_o.cur_sel = dbba_pkg::CurReq;
        end else begin
          cmd_o.st_set = 1'b0;
          cmd_o.rd_req = 1'b1;
          state_d      = dbba_pkg::CtlRmw;
        end
      end
      dbba_pkg::CtlRmw: begin
        cmd_o.st_set = 1'b1;
        state_d      = dbba_pkg::CtlFinish;
        if (stat_i.req == dbba_pkg::REQ_FREE) begin
          cmd_o.wr_free = 1'b1;
        end else if (!stat_i.req_used) begin
          cmd_o.wr_alloc = 1'b1;
          cmd_o.cur_sel  = dbba_pkg::CurReq;
        end else begin
          cmd_o.st_val = dbba_pkg::ST_NO_BLOCK;
          if (stat_i.start_wrap) begin
            cmd_o.cur_sel = dbba_pkg::CurZero;
          end else begin
            cmd_o.search_start = 1'b1;
            state_d            = dbba_pkg::CtlSearch;
          end
        end
      end
      dbba_pkg::CtlSearch: begin
        cmd_o.search_step = 1'b1;
        if (stat_i.found) begin
          cmd_o.cur_sel = dbba_pkg::CurFound;
          state_d       = dbba_pkg::CtlFinish;
        end else if (stat_i.none) begin
          cmd_o.cur_sel = dbba_pkg::CurZero;
          state_d       = dbba_pkg::CtlFinish;
        end
      end
      dbba_pkg::CtlFinish: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = dbba_pkg::CtlIdle;
        end
      end
      default: state_d = dbba_pkg::CtlClear;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/dbba_datapath.sv =====
`default_nettype none
module dbba_datapath #(
  parameter int unsigned SECTORS_PER_TRACK = dbba_pkg::SectorsPerTrackDefault,
  parameter int unsigned TRACK_COUNT       = dbba_pkg::TrackCountDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dbba_pkg::dp_cmd_t cmd_i,
  output dbba_pkg::dp_stat_t     stat_o,
  input  wire logic [1:0]        req_i,
  input  wire logic [5:0]        trk_i,
  input  wire logic [5:0]        sec_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [1:0]             status_o,
  output logic [5:0]             trk_o,
  output logic [5:0]             sec_o
);

  localparam int unsigned MapBits  = TRACK_COUNT * SECTORS_PER_TRACK;
  localparam int unsigned MapBytes = (MapBits + 7) / 8;
  localparam int unsigned IdxW     = (MapBits > 16) ? $clog2(MapBits) : 4;
  localparam int unsigned AddrW    = IdxW - 3;
  localparam logic [5:0]  LastSec  = 6'(SECTORS_PER_TRACK - 1);
  localparam logic [5:0]  LastTrk  = 6'(TRACK_COUNT);

  logic [7:0]      mem [MapBytes];
  logic [7:0]      rdata_q;

  logic [1:0]      req_q;
  logic [5:0]      trk_q, sec_q;
  logic            legal_q;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [5:0]      cur_trk_q, cur_sec_q, cur_trk_d, cur_sec_d;
  logic [1:0]      st_q;

  logic [5:0]      it_q, is_q;
  logic [IdxW-1:0] ii_q;
  logic            iend_q;
  logic [5:0]      ct_q, cs_q;
  logic [2:0]      cb_q;
  logic            cv_q;

  logic [AddrW-1:0] clr_q;

  logic            out_vld_q;
  logic [1:0]      out_st_q;
  logic [5:0]      out_trk_q, out_sec_q;

  logic [5:0]      base_t, base_s, nxt_t, nxt_s;
  logic [IdxW-1:0] base_i;
  logic            nxt_wrap;
  logic            issue;
  logic            rd_en, wr_en;
  logic [AddrW-1:0] raddr, waddr;
  logic [7:0]      wdata, mask;
  logic            chk_bit;

  assign idx_d = IdxW'((12'(trk_i) - 12'd1) * 12'(SECTORS_PER_TRACK) + 12'(sec_i));

  assign base_t   = cmd_i.search_start ? trk_q : it_q;
  assign base_s   = cmd_i.search_start ? sec_q : is_q;
  assign base_i   = cmd_i.search_start ? idx_q : ii_q;
  assign nxt_wrap = (base_s == LastSec) && (base_t == LastTrk);
  assign nxt_s    = (base_s == LastSec) ? 6'd0 : base_s + 6'd1;
  assign nxt_t    = (base_s == LastSec) ? base_t + 6'd1 : base_t;

  assign issue   = cmd_i.search_step && !iend_q;
  assign rd_en   = cmd_i.rd_req || issue;
  assign raddr   = issue ? ii_q[IdxW-1:3] : idx_q[IdxW-1:3];
  assign mask    = 8'(1) << idx_q[2:0];
  assign wr_en   = cmd_i.clear_step || cmd_i.wr_alloc || cmd_i.wr_free;
  assign waddr   = cmd_i.clear_step ? clr_q : idx_q[IdxW-1:3];
  assign wdata   = cmd_i.clear_step ? 8'd0 :
                   cmd_i.wr_alloc   ? (rdata_q | mask) : (rdata_q & ~mask);
  assign chk_bit = rdata_q[cb_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      trk_q   <= trk_i;
      sec_q   <= sec_i;
      idx_q   <= idx_d;
      legal_q <= (trk_i != 6'd0) && (trk_i <= LastTrk) &&
                 (sec_i < 6'(SECTORS_PER_TRACK));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iend_q <= 1'b0;
      cv_q   <= 1'b0;
    end else if (cmd_i.search_start) begin
      iend_q <= nxt_wrap;
      cv_q   <= 1'b0;
    end else if (cmd_i.search_step) begin
      if (!iend_q) iend_q <= nxt_wrap;
      cv_q <= !iend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_start || issue) begin
      it_q <= nxt_t;
      is_q <= nxt_s;
      ii_q <= base_i + IdxW'(1);
    end
    if (issue) begin
      ct_q <= it_q;
      cs_q <= is_q;
      cb_q <= ii_q[2:0];
    end
  end

  always_comb begin
    cur_trk_d = cur_trk_q;
    cur_sec_d = cur_sec_q;
    case (cmd_i.cur_sel)
      dbba_pkg::CurKeep: begin
      end
      dbba_pkg::CurReq: begin
        cur_trk_d = trk_q;
        cur_sec_d = sec_q;
      end
      dbba_pkg::CurHome: begin
        cur_trk_d = 6'd1;
        cur_sec_d = 6'd0;
      end
      dbba_pkg::CurZero: begin
        cur_trk_d = 6'd0;
        cur_sec_d = 6'd0;
      end
      dbba_pkg::CurFound: begin
        cur_trk_d = ct_q;
        cur_sec_d = cs_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_trk_q <= 6'd1;
      cur_sec_q <= 6'd0;
    end else begin
      cur_trk_q <= cur_trk_d;
      cur_sec_q <= cur_sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.st_set) st_q <= cmd_i.st_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_st_q  <= st_q;
      out_trk_q <= cur_trk_q;
      out_sec_q <= cur_sec_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_st_q;
  assign trk_o       = out_trk_q;
  assign sec_o       = out_sec_q;

  assign stat_o.clr_done   = cmd_i.clear_step && (clr_q == AddrW'(MapBytes - 1));
  assign stat_o.req        = req_q;
  assign stat_o.legal      = legal_q;
  assign stat_o.req_used   = rdata_q[idx_q[2:0]];
  assign stat_o.start_wrap = (sec_q == LastSec) && (trk_q == LastTrk);
  assign stat_o.found      = cv_q && !chk_bit;
  assign stat_o.none       = cv_q && chk_bit && iend_q;
  assign stat_o.out_free   = !out_vld_q || out_ready_i;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned Sectors      = dbba_pkg::SectorsPerTrackDefault;
  localparam int unsigned Tracks       = dbba_pkg::TrackCountDefault;
  localparam int unsigned MapBits      = Sectors * Tracks;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned SettleCycles = MapBits + 64;

  typedef struct packed {
    logic [1:0] req;
    logic [5:0] track;
    logic [5:0] sector;
  } map_request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] track;
    logic [5:0] sector;
  } map_reply_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data  = '0;
  logic [1:0]  s_user  = dbba_pkg::REQ_RESET_POS;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [15:0] m_data;
  logic [1:0]  m_user;

  map_request_t queued_requests[$];
  map_reply_t   predicted_replies[$];
  bit           block_used[MapBits];
  int           cur_track  = 1;
  int           cur_sector = 0;

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  logic        req_taken      = 1'b0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned ready_mode     = 0;
  int unsigned cycle_count    = 0;
  logic [15:0] pattern_light  = '1;
  logic [15:0] pattern_heavy  = 16'h0001;
  map_request_t next_request;
  map_reply_t   due_reply;
  map_reply_t   seen_reply;

  disk_block_bitmap_allocator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),   // track[5:0], sector[11:6], zero[15:12]
    .s_axis_tuser (s_user),   // req_type[1:0]
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),   // track_out[5:0], sector_out[11:6], zero[15:12]
    .m_axis_tuser (m_user)    // status[1:0]
  );

  always #2 clk_i = ~clk_i;

  function automatic int map_index(int trk, int sec);
    return (trk - 1) * Sectors + sec;
  endfunction

  function automatic map_reply_t predict_map_reply(map_request_t rq);
    map_reply_t rep;
    int         t;
    int         s;
    bit         legal;
    bit         searching;
    t          = rq.track;
    s          = rq.sector;
    rep.status = dbba_pkg::ST_OK;
    legal      = (t >= 1) && (t <= Tracks) && (s < Sectors);
    if (rq.req == dbba_pkg::REQ_RESET_POS) begin
      cur_track  = 1;
      cur_sector = 0;
    end else if (!legal) begin
      rep.status = dbba_pkg::ST_ILLEGAL;
    end else if (rq.req == dbba_pkg::REQ_ALLOC) begin
      if (!block_used[map_index(t, s)]) begin
        block_used[map_index(t, s)] = 1'b1;
      end else begin
        rep.status = dbba_pkg::ST_NO_BLOCK;
        searching  = 1'b1;
        while (searching) begin
          s++;
          if (s >= Sectors) begin
            s = 0;
            t++;
            if (t > Tracks) begin
              t         = 0;
              searching = 1'b0;
            end
          end
          if (searching && !block_used[map_index(t, s)]) searching = 1'b0;
        end
      end
      cur_track  = t;
      cur_sector = s;
    end else if (rq.req == dbba_pkg::REQ_FREE) begin
      block_used[map_index(t, s)] = 1'b0;
    end else begin
      cur_track  = t;
      cur_sector = s;
    end
    rep.track  = cur_track[5:0];
    rep.sector = cur_sector[5:0];
    return rep;
  endfunction

  task automatic add_request(logic [1:0] req, int trk, int sec);
    map_request_t rq;
    rq.req    = req;
    rq.track  = trk[5:0];
    rq.sector = sec[5:0];
    queued_requests.push_back(rq);
  endtask

  task automatic add_random_request();
    int unsigned pick;
    int          t;
    int          s;
    pick = $urandom_range(0, 99);
    t    = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, Tracks);
    s    = $urandom_range(0, Sectors - 1);
    if (pick < 55) add_request(dbba_pkg::REQ_ALLOC, t, s);
    else if (pick < 72) add_request(dbba_pkg::REQ_FREE, t, s);
    else if (pick < 82) add_request(dbba_pkg::REQ_SET_POS, t, s);
    else if (pick < 88)
      add_request(dbba_pkg::REQ_RESET_POS, $urandom_range(0, 63), $urandom_range(0, 63));
    else add_request(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || s_valid || predicted_replies.size() != 0)
      @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && !(s_valid && !req_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_valid  <= 1'b0;
      end else if (queued_requests.size() != 0) begin
        next_request = queued_requests.pop_front();
        s_valid <= 1'b1;
        s_data  <= {4'b0, next_request.sector, next_request.track};
        s_user  <= next_request.req;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 200 == 0) begin
      ready_mode    <= $urandom_range(0, 2);
      pattern_light <= 16'($urandom) | 16'h0001;
      pattern_heavy <= 16'($urandom & $urandom) | 16'h0001;
    end
    case (ready_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= pattern_light[cycle_count[3:0]];
      default: m_ready <= pattern_heavy[cycle_count[3:0]];
    endcase
  end

  always @(posedge clk_i) begin
    req_taken <= s_valid && s_ready;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        next_request.req    = s_user;
        next_request.track  = s_data[5:0];
        next_request.sector = s_data[11:6];
        predicted_replies.push_back(predict_map_reply(next_request));
      end
      if (m_valid && m_ready) begin
        seen_reply.status = m_user;
        seen_reply.track  = m_data[5:0];
        seen_reply.sector = m_data[11:6];
        if (predicted_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected reply: status %0d track %0d sector %0d",
                     seen_reply.status, seen_reply.track, seen_reply.sector);
        end else begin
          due_reply = predicted_replies.pop_front();
          if (seen_reply != due_reply || m_data[15:12] != 4'b0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: status %0d/%0d track %0d/%0d sector %0d/%0d pad %0h (exp/got)",
                       due_reply.status, seen_reply.status, due_reply.track, seen_reply.track,
                       due_reply.sector, seen_reply.sector, m_data[15:12]);
          end
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    add_request(dbba_pkg::REQ_RESET_POS, 63, 63);
    add_request(dbba_pkg::REQ_ALLOC, 1, 0);
    add_request(dbba_pkg::REQ_ALLOC, 1, 0);
    add_request(dbba_pkg::REQ_ALLOC, 1, 20);
    add_request(dbba_pkg::REQ_ALLOC, 1, 19);
    add_request(dbba_pkg::REQ_ALLOC, 1, 19);
    add_request(dbba_pkg::REQ_ALLOC, Tracks, Sectors - 1);
    add_request(dbba_pkg::REQ_ALLOC, Tracks, Sectors - 1);
    add_request(dbba_pkg::REQ_FREE, 1, 0);
    add_request(dbba_pkg::REQ_ALLOC, 1, 0);
    add_request(dbba_pkg::REQ_SET_POS, Tracks, Sectors - 1);
    add_request(dbba_pkg::REQ_SET_POS, 0, 5);
    add_request(dbba_pkg::REQ_ALLOC, Tracks + 1, 0);
    add_request(dbba_pkg::REQ_FREE, 63, 63);
    add_request(dbba_pkg::REQ_SET_POS, 1, Sectors);
    add_request(dbba_pkg::REQ_ALLOC, 1, 63);
    add_request(dbba_pkg::REQ_FREE, Tracks, 0);
    add_request(dbba_pkg::REQ_RESET_POS, 0, 0);
    add_request(dbba_pkg::REQ_ALLOC, 2, 0);
    add_request(dbba_pkg::REQ_SET_POS, 1, 0);
    add_request(dbba_pkg::REQ_RESET_POS, 42, 42);
    add_request(dbba_pkg::REQ_SET_POS, 21, 21);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (220) add_random_request();
    wait_drained();
    for (int t = Tracks - 5; t <= Tracks; t++)
      for (int s = 0; s < Sectors; s++)
        add_request(dbba_pkg::REQ_ALLOC, t, s);
    repeat (40) begin
      pick = $urandom_range(0, 99);
      add_request(pick < 70 ? dbba_pkg::REQ_ALLOC : dbba_pkg::REQ_FREE,
                  $urandom_range(Tracks - 5, Tracks), $urandom_range(0, Sectors - 1));
    end
    repeat (120) add_random_request();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
